/* design/srle_pkg.sv */
package srle_pkg;

    // Palette geometry
    localparam int PALETTE_DEPTH = 256;
    localparam int PAL_AW        = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int PAL_DW        = 25;
    localparam int MIN_WIDTH     = 8;

    // Stream widths
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 72;

    // Colour constants
    localparam logic [7:0] COL_FULL = 8'hFF;
    localparam logic [7:0] COL_NONE = 8'h00;

    // Operation codes carried on s_tuser
    typedef enum logic [1:0] {
        OP_BEGIN   = 2'd0,
        OP_PAL_WR  = 2'd1,
        OP_INDEXED = 2'd2,
        OP_DIRECT  = 2'd3
    } op_t;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    // Control from sequencer to span generator
    typedef struct packed {
        logic        begin_img;
        logic [15:0] width;
        logic        load;
        logic [7:0]  count;
        logic        step;
    } span_ctrl_t;

    // Segment offered by span generator
    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [7:0]  len;
        logic        last;
    } span_seg_t;

    function automatic logic is_magenta(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b);
        return (r == COL_FULL) && (g == COL_NONE) && (b == COL_FULL);
    endfunction

endpackage

/* design/srle_palette_ram.sv */
module srle_palette_ram (
    input  logic                       clk,
    input  logic                       we,
    input  logic [srle_pkg::PAL_AW-1:0] waddr,
    input  logic [srle_pkg::PAL_DW-1:0] wdata,
    input  logic                       re,
    input  logic [srle_pkg::PAL_AW-1:0] raddr,
    output logic [srle_pkg::PAL_DW-1:0] rdata
);
    import srle_pkg::*;

    logic [PAL_DW-1:0] mem [PALETTE_DEPTH];
    logic [PAL_DW-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, held between reads
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/srle_span_gen.sv */
module srle_span_gen (
    input  logic                   clk,
    input  logic                   rst_n,
    input  srle_pkg::span_ctrl_t   ctrl,
    output srle_pkg::span_seg_t    seg
);
    import srle_pkg::*;

    logic [15:0] col_reg;
    logic [15:0] row_reg;
    logic [15:0] width_reg;
    logic [7:0]  count_reg;

    logic [15:0] room;
    logic [15:0] count_ext;
    logic        fits;
    logic [15:0] width_clamped;

    // Room left on the current row; column is always below width
    assign room          = width_reg - col_reg;
    assign count_ext     = {8'd0, count_reg};
    assign fits          = count_ext < room;
    assign width_clamped = (ctrl.width < 16'(MIN_WIDTH)) ? 16'(MIN_WIDTH) : ctrl.width;

    always_comb
    begin
        seg.x    = col_reg;
        seg.y    = row_reg;
        seg.len  = fits ? count_reg : room[7:0];
        seg.last = count_ext <= room;
    end

    // Position, width and remaining run
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            width_reg <= 16'(MIN_WIDTH);
            count_reg <= '0;
        end
        else if (ctrl.begin_img)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            width_reg <= width_clamped;
        end
        else if (ctrl.load)
        begin
            count_reg <= ctrl.count;
        end
        else if (ctrl.step)
        begin
            count_reg <= count_reg - seg.len;
            if (fits)
            begin
                col_reg <= col_reg + count_ext;
            end
            else
            begin
                col_reg <= '0;
                if (row_reg != 16'hFFFF)
                begin
                    row_reg <= row_reg + 16'd1;
                end
            end
        end
    end

endmodule

/* design/sprite_rle_pixel_decoder_core.sv */
// Sprite RLE pixel decoder. Takes one operation per input transfer (s_tuser selects begin image,
// palette write, indexed code byte or direct RGBA pixel) and emits the decoded pixels as row
// segments of one colour, each with its start column, row and length; m_tlast marks the final
// segment caused by an input. Begin image, palette write, a zero code byte and a zero run length
// give no output. A pixel-producing input yields one or more row segments (a run of n pixels at
// width w gives up to ceil(n/w)+1 segments), since the segmenter issues one segment per cycle,
// while the output is not stalled, into a single output register and a new input is taken only
// once the last segment has been issued. The palette is a single-port-write, registered-read
// memory read once per indexed input that yields pixels; entries never written read back as
// undefined.
module sprite_rle_pixel_decoder_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // image_width, code_byte, red_in, green_in, blue_in, alpha_in
    input  logic [srle_pkg::IN_TDATA_W-1:0]  s_tdata,
    // op
    input  logic [1:0]                       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // pixel_x, pixel_y, span_length, red_out, green_out, blue_out, alpha_out
    output logic [srle_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                             m_tlast
);
    import srle_pkg::*;

    // Input fields
    logic [15:0] image_width;
    logic [7:0]  code_byte;
    logic [7:0]  red_in;
    logic [7:0]  green_in;
    logic [7:0]  blue_in;
    logic [7:0]  alpha_in;
    op_t         op;

    assign image_width = s_tdata[15:0];
    assign code_byte   = s_tdata[23:16];
    assign red_in      = s_tdata[31:24];
    assign green_in    = s_tdata[39:32];
    assign blue_in     = s_tdata[47:40];
    assign alpha_in    = s_tdata[55:48];
    assign op          = op_t'(s_tuser);

    state_t state_reg, state_next;
    logic   pending_reg, pending_next;
    logic   direct_reg, direct_next;
    logic   slot_ok_reg, slot_ok_next;
    logic [7:0] dir_r_reg, dir_g_reg, dir_b_reg, dir_a_reg;
    logic       dir_load;

    // Output register
    logic        m_valid_reg;
    logic [15:0] out_x_reg, out_y_reg;
    logic [7:0]  out_len_reg, out_r_reg, out_g_reg, out_b_reg, out_a_reg;
    logic        out_last_reg;

    // Palette port
    logic              pal_we, pal_re;
    logic [PAL_AW-1:0] pal_waddr, pal_raddr;
    logic [PAL_DW-1:0] pal_wdata, pal_rdata;

    span_ctrl_t ctrl;
    span_seg_t  seg;

    logic accept;
    logic can_emit;
    logic emit;
    logic slot_in_range;
    logic [7:0] col_r, col_g, col_b, col_a;

    assign s_tready      = (state_reg == ST_IDLE);
    assign accept        = s_tvalid && s_tready;
    assign can_emit      = !m_valid_reg || m_tready;
    assign slot_in_range = {1'b0, code_byte} < 9'(PALETTE_DEPTH);

    srle_palette_ram u_palette (
        .clk   (clk),
        .we    (pal_we),
        .waddr (pal_waddr),
        .wdata (pal_wdata),
        .re    (pal_re),
        .raddr (pal_raddr),
        .rdata (pal_rdata)
    );

    srle_span_gen u_span (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .seg   (seg)
    );

    // Sequencer: decode on transfer, then issue segments
    always_comb
    begin
        state_next   = state_reg;
        pending_next = pending_reg;
        direct_next  = direct_reg;
        slot_ok_next = slot_ok_reg;
        dir_load     = 1'b0;
        emit         = 1'b0;
        pal_we       = 1'b0;
        pal_waddr    = code_byte[PAL_AW-1:0];
        pal_wdata    = {!((code_byte == 8'd0) || is_magenta(red_in, green_in, blue_in)),
                        red_in, green_in, blue_in};
        pal_re       = 1'b0;
        pal_raddr    = code_byte[PAL_AW-1:0];
        ctrl         = '0;
        ctrl.width   = image_width;
        ctrl.count   = code_byte;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (op)
                        OP_BEGIN:
                        begin
                            ctrl.begin_img = 1'b1;
                            pending_next   = 1'b0;
                        end
                        OP_PAL_WR:
                        begin
                            pal_we = slot_in_range;
                        end
                        OP_INDEXED:
                        begin
                            if (pending_reg)
                            begin
                                pending_next = 1'b0;
                                if (code_byte != 8'd0)
                                begin
                                    pal_re       = 1'b1;
                                    pal_raddr    = '0;
                                    ctrl.load    = 1'b1;
                                    direct_next  = 1'b0;
                                    slot_ok_next = 1'b1;
                                    state_next   = ST_EMIT;
                                end
                            end
                            else if (code_byte == 8'd0)
                            begin
                                pending_next = 1'b1;
                            end
                            else
                            begin
                                pal_re       = 1'b1;
                                ctrl.load    = 1'b1;
                                ctrl.count   = 8'd1;
                                direct_next  = 1'b0;
                                slot_ok_next = slot_in_range;
                                state_next   = ST_EMIT;
                            end
                        end
                        OP_DIRECT:
                        begin
                            ctrl.load   = 1'b1;
                            ctrl.count  = 8'd1;
                            direct_next = 1'b1;
                            dir_load    = 1'b1;
                            state_next  = ST_EMIT;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_EMIT:
            begin
                if (can_emit)
                begin
                    emit      = 1'b1;
                    ctrl.step = 1'b1;
                    if (seg.last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Segment colour
    always_comb
    begin
        if (direct_reg)
        begin
            col_r = dir_r_reg;
            col_g = dir_g_reg;
            col_b = dir_b_reg;
            col_a = dir_a_reg;
        end
        else if (slot_ok_reg)
        begin
            col_r = pal_rdata[23:16];
            col_g = pal_rdata[15:8];
            col_b = pal_rdata[7:0];
            col_a = pal_rdata[24] ? COL_FULL : COL_NONE;
        end
        else
        begin
            col_r = COL_NONE;
            col_g = COL_NONE;
            col_b = COL_NONE;
            col_a = COL_NONE;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            pending_reg <= 1'b0;
            direct_reg  <= 1'b0;
            slot_ok_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pending_reg <= pending_next;
            direct_reg  <= direct_next;
            slot_ok_reg <= slot_ok_next;
            if (emit)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Direct pixel colour, magenta keyed transparent
    always_ff @(posedge clk)
    begin
        if (dir_load)
        begin
            dir_r_reg <= red_in;
            dir_g_reg <= green_in;
            dir_b_reg <= blue_in;
            dir_a_reg <= is_magenta(red_in, green_in, blue_in) ? COL_NONE : alpha_in;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_x_reg    <= seg.x;
            out_y_reg    <= seg.y;
            out_len_reg  <= seg.len;
            out_r_reg    <= col_r;
            out_g_reg    <= col_g;
            out_b_reg    <= col_b;
            out_a_reg    <= col_a;
            out_last_reg <= seg.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {out_a_reg, out_b_reg, out_g_reg, out_r_reg, out_len_reg,
                       out_y_reg, out_x_reg};

endmodule

/* design/srle_checker.sv */
module srle_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [1:0]                       s_tuser,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [srle_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic                             m_tlast
);
    import srle_pkg::*;

    // Held segment stays put until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output segment changed while stalled");

    // Every segment carries at least one pixel
    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[39:32] != 8'd0)
        else $error("segment of zero length");

    // While a run is unfinished no new input is taken
    a_run_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input ready with run still in progress");

    // A direct pixel always yields a segment before the next input
    a_direct_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == OP_DIRECT) |=> !s_tready)
        else $error("direct pixel produced no segment");

    // Begin image gives no output and keeps the input open
    a_begin_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == OP_BEGIN) |=> s_tready)
        else $error("begin image stalled the input");

endmodule

bind sprite_rle_pixel_decoder_core srle_checker u_srle_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
